// ===== hdl/u16u8_pkg.sv =====
// types, constants and byte formatting shared by the utf-16 to utf-8 transcoder
// no dependencies
package u16u8_pkg;

    localparam int UNIT_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int POINT_W = 21;
    localparam int TEN_W   = 10;
    localparam int TAG_W   = UNIT_W - TEN_W;

    localparam logic [TAG_W-1:0]   HIGH_TAG     = 6'h36;
    localparam logic [TAG_W-1:0]   LOW_TAG      = 6'h37;
    localparam logic [UNIT_W-1:0]  PAD_UNIT     = 16'hFFFF;
    localparam logic [POINT_W-1:0] REPLACE_CHAR = 21'h00003F;
    localparam logic [POINT_W-1:0] PLANE_BASE   = 21'h010000;

    // index of the final byte: 0 for one byte up to 3 for four bytes
    localparam logic [1:0] LAST_ONE   = 2'd0;
    localparam logic [1:0] LAST_TWO   = 2'd1;
    localparam logic [1:0] LAST_THREE = 2'd2;
    localparam logic [1:0] LAST_FOUR  = 2'd3;

    typedef struct packed {
        logic [POINT_W-1:0] point;
        logic [1:0]         last_idx;
    } t_cmd;

    function automatic logic [BYTE_W-1:0] cont_byte(input logic [5:0] bits);
        return {2'b10, bits};
    endfunction

    function automatic logic [BYTE_W-1:0] encode_byte(
        input logic [POINT_W-1:0] point,
        input logic [1:0]         last_idx,
        input logic [1:0]         idx
    );
        logic [BYTE_W-1:0] b;
        b = 8'h00;
        unique case (last_idx)
            LAST_ONE: begin
                b = {1'b0, point[6:0]};
            end
            LAST_TWO: begin
                b = (idx == 2'd0) ? {3'b110, point[10:6]} : cont_byte(point[5:0]);
            end
            LAST_THREE: begin
                unique case (idx)
                    2'd0:    b = {4'b1110, point[15:12]};
                    2'd1:    b = cont_byte(point[11:6]);
                    default: b = cont_byte(point[5:0]);
                endcase
            end
            default: begin
                unique case (idx)
                    2'd0:    b = {5'b11110, point[20:18]};
                    2'd1:    b = cont_byte(point[17:12]);
                    2'd2:    b = cont_byte(point[11:6]);
                    default: b = cont_byte(point[5:0]);
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/u16u8_unit_if.sv =====
// valid/ready channel carrying one utf-16 code unit per beat
// depends on u16u8_pkg
interface u16u8_unit_if
    import u16u8_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [UNIT_W-1:0] code_unit;

    modport source (output valid, output code_unit, input ready);
    modport sink   (input valid, input code_unit, output ready);
endinterface

// ===== hdl/u16u8_byte_if.sv =====
// valid/ready channel carrying one utf-8 byte and its final flag per beat
// depends on u16u8_pkg
interface u16u8_byte_if
    import u16u8_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              final_byte;

    modport source (output valid, output out_byte, output final_byte, input ready);
    modport sink   (input valid, input out_byte, input final_byte, output ready);
endinterface

// ===== hdl/u16u8_front.sv =====
// front end: accepts code units, pairs surrogates, pushes encode commands
// depends on u16u8_pkg
module u16u8_front
    import u16u8_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_valid,
    input  logic [UNIT_W-1:0] i_code_unit,
    output logic              o_ready,
    output logic              o_push,
    output t_cmd              o_cmd,
    input  logic              i_push_ready
);
    logic             r_skip, n_skip;
    logic             r_pend, n_pend;
    logic [TEN_W-1:0] r_high, n_high;

    logic [TAG_W-1:0] tag;
    logic             accept;
    logic             want_push;

    assign tag     = i_code_unit[UNIT_W-1:TEN_W];
    assign o_ready = i_push_ready;
    assign accept  = i_valid && i_push_ready;
    assign o_push  = accept && want_push;

    always_comb begin
        n_skip    = i_cfg_we ? i_cfg_wdata : r_skip;
        n_pend    = r_pend;
        n_high    = r_high;
        want_push = 1'b0;
        o_cmd     = '{point: REPLACE_CHAR, last_idx: LAST_ONE};
        priority if (r_pend) begin
            want_push = 1'b1;
            if (accept) begin
                n_pend = 1'b0;
                n_high = '0;
            end
            if (tag == LOW_TAG) begin
                o_cmd.point    = {1'b0, r_high, i_code_unit[TEN_W-1:0]} + PLANE_BASE;
                o_cmd.last_idx = LAST_FOUR;
            end
        end else if (r_skip && i_code_unit == PAD_UNIT) begin
            want_push = 1'b0;
        end else if (tag == HIGH_TAG) begin
            if (accept) begin
                n_pend = 1'b1;
                n_high = i_code_unit[TEN_W-1:0];
            end
        end else begin
            want_push   = 1'b1;
            o_cmd.point = {5'd0, i_code_unit};
            priority if (i_code_unit < 16'h0080) begin
                o_cmd.last_idx = LAST_ONE;
            end else if (i_code_unit < 16'h0800) begin
                o_cmd.last_idx = LAST_TWO;
            end else begin
                o_cmd.last_idx = LAST_THREE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= 1'b1;
            r_pend <= 1'b0;
            r_high <= '0;
        end else begin
            r_skip <= n_skip;
            r_pend <= n_pend;
            r_high <= n_high;
        end
    end
endmodule

// ===== hdl/u16u8_queue.sv =====
// small command queue between front and back ends
// depends on u16u8_pkg
module u16u8_queue
    import u16u8_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_push_ready,
    input  logic i_pop,
    output logic o_head_valid,
    output t_cmd o_head
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_push_ready = (r_cnt != FULL_CNT);
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end
endmodule

// ===== hdl/u16u8_back.sv =====
// back end: walks each command byte by byte into the output register
// depends on u16u8_pkg
module u16u8_back
    import u16u8_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  t_cmd              i_head,
    output logic              o_pop,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_final_byte,
    input  logic              i_ready
);
    logic              r_valid, n_valid;
    logic [1:0]        r_idx, n_idx;
    logic [BYTE_W-1:0] r_byte;
    logic              r_final;

    logic load;
    logic last;

    assign load  = i_head_valid && (!r_valid || i_ready);
    assign last  = (r_idx == i_head.last_idx);
    assign o_pop = load && last;

    assign o_valid      = r_valid;
    assign o_out_byte   = r_byte;
    assign o_final_byte = r_final;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = last ? 2'd0 : r_idx + 2'd1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte  <= encode_byte(i_head.point, i_head.last_idx, r_idx);
            r_final <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end
endmodule

// ===== hdl/utf16_to_utf8_transcoder.sv =====
// utf-16 to utf-8 transcoder top level: front end, command queue, back end
// each encode command is written into the queue, then its bytes into the output register
// throughput: one byte per cycle while a command is queued and the byte sink is ready;
//   a command gives 1 to 4 bytes, units with no output push nothing, QUEUE_DEPTH commands buffer
// synchronous active-low reset: skip_padding set, held surrogate dropped, queue emptied
// depends on u16u8_pkg, u16u8_unit_if, u16u8_byte_if, u16u8_front, u16u8_queue, u16u8_back
module utf16_to_utf8_transcoder
    import u16u8_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    u16u8_unit_if.sink   i_unit,
    u16u8_byte_if.source o_byte
);
    logic push;
    logic push_ready;
    t_cmd cmd;
    logic pop;
    logic head_valid;
    t_cmd head;

    u16u8_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_unit.valid),
        .i_code_unit  (i_unit.code_unit),
        .o_ready      (i_unit.ready),
        .o_push       (push),
        .o_cmd        (cmd),
        .i_push_ready (push_ready)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (cmd),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    u16u8_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_byte.valid),
        .o_out_byte   (o_byte.out_byte),
        .o_final_byte (o_byte.final_byte),
        .i_ready      (o_byte.ready)
    );
endmodule

// ===== sim/u16u8_checker.sv =====
// utf-8 beat checker for the utf-16 to utf-8 transcoder: follows the unit and byte channels,
// keeps its own copy of the surrogate and padding state, and compares every byte beat
// depends on u16u8_pkg, u16u8_unit_if, u16u8_byte_if
module u16u8_checker
    import u16u8_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_we,
    input  logic  i_cfg_wdata,
    u16u8_unit_if i_unit_mon,
    u16u8_byte_if i_byte_mon,
    output int    o_fail_cnt,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } t_utf8_beat;

    t_utf8_beat        utf8_due[$];
    logic              skip_pad;
    logic              high_held;
    logic [TEN_W-1:0]  held_bits;

    task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] exp_v,
                                   input logic [BYTE_W-1:0] got_v);
        $display("[%0t] utf8 beat mismatch on %s: expected %h got %h", $time, what, exp_v, got_v);
        o_fail_cnt++;
    endtask

    function automatic void push_beat(input logic [BYTE_W-1:0] value, input logic last);
        t_utf8_beat b;
        b.value = value;
        b.last  = last;
        utf8_due.push_back(b);
    endfunction

    function automatic void push_point(input logic [POINT_W-1:0] cp);
        if (cp < 21'h80) begin
            push_beat({1'b0, cp[6:0]}, 1'b1);
        end else if (cp < 21'h800) begin
            push_beat({3'b110, cp[10:6]}, 1'b0);
            push_beat({2'b10, cp[5:0]}, 1'b1);
        end else if (cp < 21'h10000) begin
            push_beat({4'b1110, cp[15:12]}, 1'b0);
            push_beat({2'b10, cp[11:6]}, 1'b0);
            push_beat({2'b10, cp[5:0]}, 1'b1);
        end else begin
            push_beat({5'b11110, cp[20:18]}, 1'b0);
            push_beat({2'b10, cp[17:12]}, 1'b0);
            push_beat({2'b10, cp[11:6]}, 1'b0);
            push_beat({2'b10, cp[5:0]}, 1'b1);
        end
    endfunction

    function automatic void predict_unit(input logic [UNIT_W-1:0] u);
        logic [TAG_W-1:0] tag;
        tag = u[UNIT_W-1:TEN_W];
        if (high_held) begin
            high_held = 1'b0;
            if (tag == LOW_TAG) begin
                push_point(PLANE_BASE + {1'b0, held_bits, u[TEN_W-1:0]});
            end else begin
                push_beat(REPLACE_CHAR[BYTE_W-1:0], 1'b1);
            end
            held_bits = '0;
        end else if (skip_pad && u == PAD_UNIT) begin
            // padding dropped
        end else if (tag == HIGH_TAG) begin
            high_held = 1'b1;
            held_bits = u[TEN_W-1:0];
        end else begin
            push_point({{(POINT_W-UNIT_W){1'b0}}, u});
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_utf8_beat exp_b;
        if (!i_rst_n) begin
            skip_pad  = 1'b1;
            high_held = 1'b0;
            held_bits = '0;
            utf8_due.delete();
        end else begin
            // compare first: a unit accepted at this edge cannot produce a beat at it
            if (i_byte_mon.valid && i_byte_mon.ready) begin
                if (utf8_due.size() == 0) begin
                    report_mismatch("unexpected beat", 'x, i_byte_mon.out_byte);
                end else begin
                    exp_b = utf8_due.pop_front();
                    if (i_byte_mon.out_byte !== exp_b.value)
                        report_mismatch("out_byte", exp_b.value, i_byte_mon.out_byte);
                    if (i_byte_mon.final_byte !== exp_b.last)
                        report_mismatch("final_byte", {7'd0, exp_b.last},
                                        {7'd0, i_byte_mon.final_byte});
                end
            end
            if (i_cfg_we)
                skip_pad = i_cfg_wdata;
            if (i_unit_mon.valid && i_unit_mon.ready)
                predict_unit(i_unit_mon.code_unit);
        end
        o_pending = utf8_due.size();
    end

endmodule

// ===== sim/tb_utf16_to_utf8_transcoder.sv =====
// testbench top for the utf-16 to utf-8 transcoder: clock, reset, unit stimulus with
// random gaps, byte sink with random stalls, padding-skip phases and the final verdict
// depends on u16u8_pkg, u16u8_unit_if, u16u8_byte_if, u16u8_checker, utf16_to_utf8_transcoder
module tb_utf16_to_utf8_transcoder;
    timeunit 1ns;
    timeprecision 1ps;
    import u16u8_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_UNITS   = 86;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    int          fail_cnt;
    int          pending_cnt;
    int          sent;
    bit          no_idle;
    int unsigned cycle_cnt;

    logic [UNIT_W-1:0] directed_units[] = '{
        16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD7FF, 16'hE000, 16'hFFFE,
        16'hFFFF, 16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF, 16'hDC00, 16'hDFFF,
        16'hD800, 16'h0041, 16'hD800, 16'hDBFF, 16'hDBFF, 16'hFFFF
    };

    u16u8_unit_if unit_ch ();
    u16u8_byte_if byte_ch ();

    utf16_to_utf8_transcoder DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_unit      (unit_ch),
        .o_byte      (byte_ch)
    );

    u16u8_checker utf8_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_unit_mon  (unit_ch),
        .i_byte_mon  (byte_ch),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending_cnt)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_unit(input logic [UNIT_W-1:0] u);
        int gap;
        unit_ch.valid     <= 1'b1;
        unit_ch.code_unit <= u;
        do @(posedge clk); while (unit_ch.ready !== 1'b1);
        sent++;
        gap = pick_gap();
        if (gap > 0) begin
            unit_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        unit_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending_cnt == 0);
        @(posedge clk);
    endtask

    task automatic write_skip(input logic v);
        wait_drained();
        // a held surrogate or skipped padding leaves no beat to wait for
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_random();
        int kind;
        int pick;
        kind = $urandom_range(0, 99);
        pick = $urandom_range(0, 2);
        if (kind < 25) begin
            send_unit({HIGH_TAG, 10'($urandom)});
            send_unit({LOW_TAG, 10'($urandom)});
        end else if (kind < 45) begin
            send_unit(16'($urandom_range(16'h0000, 16'h007F)));
        end else if (kind < 60) begin
            send_unit(16'($urandom_range(16'h0080, 16'h07FF)));
        end else if (kind < 75) begin
            if (pick == 0)
                send_unit(16'($urandom_range(16'hE000, 16'hFFFE)));
            else
                send_unit(16'($urandom_range(16'h0800, 16'hD7FF)));
        end else if (kind < 80) begin
            send_unit(PAD_UNIT);
        end else if (kind < 85) begin
            send_unit({LOW_TAG, 10'($urandom)});
        end else if (kind < 90) begin
            // broken pair
            send_unit({HIGH_TAG, 10'($urandom)});
            if (pick == 0)
                send_unit({HIGH_TAG, 10'($urandom)});
            else if (pick == 1)
                send_unit(PAD_UNIT);
            else
                send_unit(16'($urandom_range(16'h0000, 16'hD7FF)));
        end else begin
            send_unit(16'($urandom));
        end
    endtask

    initial begin : byte_sink
        int hold;
        hold = 0;
        byte_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                byte_ch.ready <= 1'b0;
                hold--;
            end else begin
                byte_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    hold = pick_gap();
            end
        end
    end

    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int target;
        sent              = 0;
        no_idle           = 1'b0;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= 1'b0;
        unit_ch.valid     <= 1'b0;
        unit_ch.code_unit <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_units[i])
            send_unit(directed_units[i]);

        // padding with skip off, and padding after a held surrogate
        write_skip(1'b0);
        send_unit(PAD_UNIT);
        send_unit(16'hD800);
        send_unit(PAD_UNIT);
        send_unit(16'hFFFE);

        for (int ph = 0; ph < 4; ph++) begin
            write_skip(ph[0] ? 1'b0 : 1'b1);
            no_idle = (ph == 1);
            target  = sent + PHASE_UNITS;
            while (sent < target) begin
                send_random();
                if ($urandom_range(0, 39) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
